[hdl/dlff_pkg.sv]
package dlff_pkg;

	localparam int BYTE_W     = 8;
	localparam int CAP_W      = 15;
	localparam int COUNT_W    = 15;
	localparam int IDX_W      = 2;
	localparam int CFG_DATA_W = 15;

	// Limit applied to the capacity register
	localparam int MAX_CAPACITY_DEF = 16384;

	// Result queue depth; must be a power of two, at least 2
	localparam int FIFO_DEPTH = 4;

	localparam logic [CAP_W-1:0]  CAPACITY_RST = 15'd10240;
	localparam logic [BYTE_W-1:0] START_RST    = 8'd1;
	localparam logic [BYTE_W-1:0] END_RST      = 8'd2;

	localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_DONE = 2'd1,
		KIND_OVFL = 2'd2
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_CAPACITY = 2'd0,
		REG_START    = 2'd1,
		REG_END      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CAP_W-1:0]  capacity;
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] end_byte;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  data;
		logic [COUNT_W-1:0] count;
		logic               last;
	} res_t;

	// Up to two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

[hdl/delimited_file_list_filter_core.sv]
// Delimited file-list filter. Bytes arrive on in_byte and are ignored until
// start_byte opens the list text; inside it '@', tab, space, CR and '*' turn
// into newline, leading and repeated newlines are dropped, and a '/' right
// before a newline is removed, so the last written character is always held
// back one item. end_byte flushes the held character and emits a done status
// (kind 1) with the name count; reaching capacity emits overflow (kind 2)
// instead; either way the block then waits for a new start_byte. Each input
// item gives zero, one or two results, is_last marking the final one. Rate:
// one item per clock while the result queue has room; an item waits in the
// input register, where it updates the filter state, and its results then
// wait in a four-entry result queue. in_stall rises only while that
// queue cannot take two more results. Configuration writes are always taken
// (cfg_ready is tied high) and must happen with the block idle.
module delimited_file_list_filter_core #(
	parameter int MAX_CAPACITY = dlff_pkg::MAX_CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// input bytes
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [dlff_pkg::BYTE_W-1:0]       in_byte,

	// results
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        kind,
	output logic [dlff_pkg::BYTE_W-1:0]       out_byte,
	output logic [dlff_pkg::COUNT_W-1:0]      name_count,
	output logic                              is_last,

	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [dlff_pkg::IDX_W-1:0]        cfg_index,
	input  logic [dlff_pkg::CFG_DATA_W-1:0]   cfg_data
);

	dlff_pkg::cfg_t   cfg;
	dlff_pkg::push_t  push;
	dlff_pkg::res_t   head;
	logic             room;

	// capacity, start and end bytes
	dlff_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register plus per-byte filter decision and list state
	dlff_filter #(
		.MAX_CAPACITY (MAX_CAPACITY)
	) u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.cfg      (cfg),
		.room     (room),
		.push     (push)
	);

	// result queue; separates the output handshake from the filter
	dlff_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign kind       = head.kind;
	assign out_byte   = head.data;
	assign name_count = head.count;
	assign is_last    = head.last;

endmodule

[hdl/dlff_cfg.sv]
module dlff_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dlff_pkg::IDX_W-1:0]          cfg_index,
	input  logic [dlff_pkg::CFG_DATA_W-1:0]     cfg_data,
	output dlff_pkg::cfg_t                      cfg
);

	dlff_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity   <= dlff_pkg::CAPACITY_RST;
			cfg_q.start_byte <= dlff_pkg::START_RST;
			cfg_q.end_byte   <= dlff_pkg::END_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dlff_pkg::REG_CAPACITY: begin
					cfg_q.capacity <= cfg_data[dlff_pkg::CAP_W-1:0];
				end
				dlff_pkg::REG_START: begin
					cfg_q.start_byte <= cfg_data[dlff_pkg::BYTE_W-1:0];
				end
				dlff_pkg::REG_END: begin
					cfg_q.end_byte <= cfg_data[dlff_pkg::BYTE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hdl/dlff_filter.sv]
module dlff_filter #(
	parameter int MAX_CAPACITY = dlff_pkg::MAX_CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dlff_pkg::BYTE_W-1:0]   in_byte,
	input  dlff_pkg::cfg_t                cfg,
	input  logic                          room,
	output dlff_pkg::push_t               push
);

	localparam int CMP_W = dlff_pkg::CAP_W + 2;
	localparam logic [CMP_W-1:0] CAP_LIMIT = CMP_W'(MAX_CAPACITY);

	logic                            valid_s1;
	logic [dlff_pkg::BYTE_W-1:0]     byte_s1;
	logic                            advance;

	logic                            in_text_q, in_text_d;
	logic [dlff_pkg::BYTE_W-1:0]     held_char_q, held_char_d;
	logic                            held_valid_q, held_valid_d;
	logic [dlff_pkg::CAP_W-1:0]      wl_q, wl_d;
	logic [dlff_pkg::COUNT_W-1:0]    nc_q, nc_d;

	logic [CMP_W-1:0]                cap_eff;
	logic                            ovfl_hit;
	logic                            is_end;
	logic [dlff_pkg::BYTE_W-1:0]     mapped;
	logic                            is_nl;
	logic [dlff_pkg::COUNT_W-1:0]    nc_inc;
	dlff_pkg::kind_t                 status_kind;

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		cap_eff = ({2'b00, cfg.capacity} > CAP_LIMIT) ? CAP_LIMIT : {2'b00, cfg.capacity};
		ovfl_hit = ({2'b00, wl_q} + CMP_W'(1)) >= cap_eff;
		is_end = (byte_s1 == cfg.end_byte);
		status_kind = is_end ? dlff_pkg::KIND_DONE : dlff_pkg::KIND_OVFL;
		if (byte_s1 inside {dlff_pkg::CH_AT, dlff_pkg::CH_TAB, dlff_pkg::CH_SP,
				dlff_pkg::CH_CR, dlff_pkg::CH_STAR}) begin
			mapped = dlff_pkg::CH_NL;
		end else begin
			mapped = byte_s1;
		end
		is_nl  = (mapped == dlff_pkg::CH_NL);
		nc_inc = nc_q + dlff_pkg::COUNT_W'(1);
	end

	always_comb begin
		in_text_d    = in_text_q;
		held_char_d  = held_char_q;
		held_valid_d = held_valid_q;
		wl_d         = wl_q;
		nc_d         = nc_q;
		push.num     = 2'd0;
		push.r0      = '{kind: dlff_pkg::KIND_CHAR, data: held_char_q, count: nc_q, last: 1'b0};
		push.r1      = '{kind: status_kind, data: '0, count: nc_q, last: 1'b1};
		if (advance) begin
			if (!in_text_q) begin
				if (byte_s1 == cfg.start_byte) begin
					in_text_d    = 1'b1;
					held_valid_d = 1'b0;
					held_char_d  = '0;
					wl_d         = '0;
					nc_d         = '0;
				end
			end else if (is_end || ovfl_hit) begin
				// flush held char, then status
				if (held_valid_q) begin
					push.num = 2'd2;
				end else begin
					push.num = 2'd1;
					push.r0  = '{kind: status_kind, data: '0, count: nc_q, last: 1'b1};
				end
				in_text_d    = 1'b0;
				held_valid_d = 1'b0;
			end else if (is_nl && (!held_valid_q || held_char_q == dlff_pkg::CH_NL)) begin
				// leading or repeated newline: dropped
			end else if (is_nl && held_char_q == dlff_pkg::CH_SLASH) begin
				held_char_d = dlff_pkg::CH_NL;
				nc_d        = nc_inc;
			end else begin
				if (is_nl) begin
					nc_d = nc_inc;
				end
				if (held_valid_q) begin
					push.num = 2'd1;
					push.r0  = '{kind: dlff_pkg::KIND_CHAR, data: held_char_q,
						count: (is_nl ? nc_inc : nc_q), last: 1'b1};
				end
				held_char_d  = mapped;
				held_valid_d = 1'b1;
				wl_d         = wl_q + dlff_pkg::CAP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_text_q    <= 1'b0;
			held_char_q  <= '0;
			held_valid_q <= 1'b0;
			wl_q         <= '0;
			nc_q         <= '0;
		end else begin
			in_text_q    <= in_text_d;
			held_char_q  <= held_char_d;
			held_valid_q <= held_valid_d;
			wl_q         <= wl_d;
			nc_q         <= nc_d;
		end
	end

	a_held_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> in_text_q)
		else $error("held char outside list text");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num == 2'd1) |-> push.r0.last)
		else $error("single result not marked last");

	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num == 2'd2) |-> (!push.r0.last && push.r1.last &&
		push.r0.kind == dlff_pkg::KIND_CHAR && push.r1.kind != dlff_pkg::KIND_CHAR))
		else $error("result pair malformed");

endmodule

[hdl/dlff_fifo.sv]
module dlff_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  dlff_pkg::push_t   push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output dlff_pkg::res_t    head
);

	localparam int DEPTH = dlff_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	dlff_pkg::res_t        mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room      = (count_q <= CNT_W'(DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.num) - CNT_W'(pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue overfilled");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.num != 2'd0) |-> room)
		else $error("push without room");

endmodule

[test/delimited_file_list_filter_core_test.sv]
`timescale 1ns / 100ps

// Testbench for the delimited file-list filter.
// Bytes go in one item at a time through a valid/stall channel. A behavioral
// model of the filter predicts the results of every accepted byte, and the
// output monitor compares each accepted result field by field with the oldest
// prediction. The register port is written only while the block is drained.
module delimited_file_list_filter_core_test;

	localparam int MAX_CAP       = dlff_pkg::MAX_CAPACITY_DEF;
	localparam int SETTLE_CYCLES = 8;          // input register plus result queue, with margin
	localparam int RUN_LIMIT     = 1_500_000;  // cycles before the run is declared hung
	localparam int RANDOM_ITEMS  = 960;
	localparam int PHASE_ITEMS   = 120;
	localparam int CLAMP_ITEMS   = 48;

	// index 3 has no register behind it; writes there must change nothing
	localparam logic [dlff_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	logic [dlff_pkg::BYTE_W-1:0]     in_byte   = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [1:0]                      kind;
	logic [dlff_pkg::BYTE_W-1:0]     out_byte;
	logic [dlff_pkg::COUNT_W-1:0]    name_count;
	logic                            is_last;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [dlff_pkg::IDX_W-1:0]      cfg_index = '0;
	logic [dlff_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	delimited_file_list_filter_core #(
		.MAX_CAPACITY(MAX_CAP)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_byte  (out_byte),
		.name_count(name_count),
		.is_last   (is_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------------
	// Filter model: registers and list state, reset values as in hardware
	// ---------------------------------------------------------------------
	logic [dlff_pkg::CAP_W-1:0]   cap_setting = dlff_pkg::CAPACITY_RST;
	logic [dlff_pkg::BYTE_W-1:0]  open_byte   = dlff_pkg::START_RST;
	logic [dlff_pkg::BYTE_W-1:0]  close_byte  = dlff_pkg::END_RST;
	logic                         in_list     = 1'b0;
	logic [dlff_pkg::BYTE_W-1:0]  held_ch     = '0;
	logic                         held_ok     = 1'b0;
	int                           written_len = 0;
	logic [dlff_pkg::COUNT_W-1:0] names_seen  = '0;

	dlff_pkg::res_t list_output_q[$];   // predicted results, oldest first

	int  mismatch_count = 0;
	int  random_sent    = 0;  // list bytes sent by the random part, noise excluded
	int  cycle_count    = 0;
	bit  sender_gaps    = 1'b1;
	int  stall_pct      = 20; // chance per cycle that the receiver starts a stall
	int  hold_off_len   = 0;  // long receiver hold-off requested by a test

	// Works out the results of one accepted byte and queues them.
	function automatic void filter_byte(input logic [dlff_pkg::BYTE_W-1:0] b);
		dlff_pkg::res_t              outs[2];
		int                          n;
		int                          lim;
		dlff_pkg::kind_t             status;
		logic [dlff_pkg::BYTE_W-1:0] c;
		n = 0;
		if (!in_list) begin
			// outside the list only the opening byte matters
			if (b == open_byte) begin
				in_list     = 1'b1;
				held_ok     = 1'b0;
				held_ch     = '0;
				written_len = 0;
				names_seen  = '0;
			end
			return;
		end
		lim = (cap_setting > MAX_CAP) ? MAX_CAP : int'(cap_setting);
		// the closing byte wins over the capacity check
		if (b == close_byte || written_len + 1 >= lim) begin
			if (b == close_byte)
				status = dlff_pkg::KIND_DONE;
			else
				status = dlff_pkg::KIND_OVFL;
			if (held_ok) begin
				outs[n] = '{kind: dlff_pkg::KIND_CHAR, data: held_ch, count: names_seen,
					last: 1'b0};
				n++;
			end
			outs[n] = '{kind: status, data: '0, count: names_seen, last: 1'b0};
			n++;
			in_list = 1'b0;
			held_ok = 1'b0;
		end else begin
			c = b;
			if (c == dlff_pkg::CH_AT || c == dlff_pkg::CH_TAB || c == dlff_pkg::CH_SP ||
					c == dlff_pkg::CH_CR || c == dlff_pkg::CH_STAR)
				c = dlff_pkg::CH_NL;
			// leading and repeated separators vanish
			if (c == dlff_pkg::CH_NL && (!held_ok || held_ch == dlff_pkg::CH_NL))
				return;
			// a slash right before a separator is overwritten by it
			if (c == dlff_pkg::CH_NL && held_ch == dlff_pkg::CH_SLASH) begin
				held_ch = dlff_pkg::CH_NL;
				names_seen++;
				return;
			end
			if (c == dlff_pkg::CH_NL)
				names_seen++;
			if (held_ok) begin
				outs[n] = '{kind: dlff_pkg::KIND_CHAR, data: held_ch, count: names_seen,
					last: 1'b0};
				n++;
			end
			held_ch = c;
			held_ok = 1'b1;
			written_len++;
		end
		for (int i = 0; i < n; i++) begin
			outs[i].last = (i == n - 1);
			list_output_q.push_back(outs[i]);
		end
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	// Idle lengths from three ranges, the shortest most likely, the longest rarest.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Text byte weighted toward separators and slashes so that the
	// drop and overwrite paths are hit often.
	function automatic logic [dlff_pkg::BYTE_W-1:0] pick_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return 8'h61 + 8'($urandom_range(25));
		if (r < 60) begin
			case ($urandom_range(6))
				0: return dlff_pkg::CH_AT;
				1: return dlff_pkg::CH_TAB;
				2: return dlff_pkg::CH_SP;
				3: return dlff_pkg::CH_CR;
				4: return dlff_pkg::CH_STAR;
				5: return dlff_pkg::CH_NL;
				default: return dlff_pkg::CH_SLASH;
			endcase
		end
		if (r < 75)
			return dlff_pkg::CH_SLASH;
		if (r < 80)
			return open_byte;
		return 8'($urandom);
	endfunction

	// Offers one byte, waits for it to be taken, then predicts its results.
	task automatic send_byte(input logic [dlff_pkg::BYTE_W-1:0] b);
		int gap;
		gap = (sender_gaps && $urandom_range(3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		filter_byte(b);
	endtask

	// Drops valid and waits until every predicted result has been seen, then
	// lets the pipeline settle, since a byte may be in flight with no result.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (list_output_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dlff_pkg::IDX_W-1:0] idx,
			input logic [dlff_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			dlff_pkg::REG_CAPACITY: cap_setting = val;
			dlff_pkg::REG_START:    open_byte   = val[dlff_pkg::BYTE_W-1:0];
			dlff_pkg::REG_END:      close_byte  = val[dlff_pkg::BYTE_W-1:0];
			default:                ;
		endcase
	endtask

	// Writes all registers back to back; unused upper data bits are random.
	task automatic set_registers(input int cap, input logic [dlff_pkg::BYTE_W-1:0] sb,
			input logic [dlff_pkg::BYTE_W-1:0] eb);
		wait_idle();
		write_reg(dlff_pkg::REG_CAPACITY, dlff_pkg::CFG_DATA_W'(cap));
		write_reg(dlff_pkg::REG_START, {7'($urandom), sb});
		write_reg(dlff_pkg::REG_END, {7'($urandom), eb});
		write_reg(REG_SPARE, dlff_pkg::CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// One list: a little noise, the opening byte, text, and usually the
	// closing byte. Lists left open feed their successor as plain text.
	task automatic send_list();
		int len;
		len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 16);
		repeat ($urandom_range(0, 2))
			send_byte(8'($urandom));
		send_byte(open_byte);
		repeat (len)
			send_byte(pick_text_byte());
		random_sent += len + 1;
		if ($urandom_range(9) != 0) begin
			send_byte(close_byte);
			random_sent++;
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("%0t: %s", $realtime, msg);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset values of the registers: start 1, end 2. Covers bytes ignored
	// outside the list, each byte mapped to newline, dropped separators, slash overwrite,
	// the start byte as text, zero and high bytes, and a held slash flushed at
	// the end of the list.
	task automatic test_reset_registers();
		send_byte(8'h41);
		send_byte(8'h02);
		send_byte(8'h01);
		send_byte(dlff_pkg::CH_AT);
		send_byte(8'h61);
		send_byte(dlff_pkg::CH_SLASH);
		send_byte(dlff_pkg::CH_SP);
		send_byte(dlff_pkg::CH_TAB);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(dlff_pkg::CH_CR);
		send_byte(dlff_pkg::CH_STAR);
		send_byte(8'h7F);
		send_byte(dlff_pkg::CH_SLASH);
		send_byte(8'h02);
	endtask

	// Capacity of zero and one overflow on the first text byte, but the
	// closing byte still wins; capacity two overflows on the second byte.
	task automatic test_small_capacity();
		set_registers(0, 8'hFF, 8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h78);
		set_registers(1, 8'h00, 8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		set_registers(2, 8'h00, 8'hFF);
		send_byte(8'h00);
		send_byte(8'h61);
		send_byte(dlff_pkg::CH_SLASH);
	endtask

	// Capacity beyond the block's maximum is clamped to the maximum, still a
	// large buffer: a run of plain letters closes with no overflow.
	task automatic test_capacity_limit();
		set_registers(32767, 8'h00, 8'hFF);
		sender_gaps = 1'b0;
		stall_pct   = 0;
		send_byte(8'h00);
		repeat (CLAMP_ITEMS)
			send_byte(8'h61 + 8'($urandom_range(25)));
		send_byte(8'hFF);
		wait_idle();
	endtask

	// The receiver holds off for a long stretch while bytes keep coming, so
	// the result queue fills and the input channel stalls.
	task automatic test_backpressure();
		set_registers(20, 8'h5B, 8'h5D);
		sender_gaps  = 1'b0;
		hold_off_len = 200;
		repeat (6)
			send_list();
		wait_idle();
	endtask

	// Random lists under a rotation of register settings and idling styles.
	task automatic test_random_lists();
		int                          phase;
		int                          phase_start;
		int                          cap;
		logic [dlff_pkg::BYTE_W-1:0] sb;
		logic [dlff_pkg::BYTE_W-1:0] eb;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			sb = 8'($urandom);
			eb = 8'($urandom);
			case (phase % 8)
				0: begin cap = 2; sb = 8'h00; eb = 8'hFF; end
				1: begin cap = MAX_CAP; sb = 8'hFF; eb = 8'h00; end
				2: begin cap = 32767; eb = sb; end      // start and end bytes are the same
				3: cap = $urandom_range(3, 12);
				4: cap = $urandom_range(13, 60);
				5: cap = $urandom_range(2, 32767);
				6: cap = $urandom_range(0, 1);
				default: cap = $urandom_range(4, 40);
			endcase
			set_registers(cap, sb, eb);
			case (phase % 4)
				0: begin sender_gaps = 1'b1; stall_pct = 25; end
				1: begin sender_gaps = 1'b0; stall_pct = 0; end
				2: begin sender_gaps = 1'b1; stall_pct = 0; end
				default: begin sender_gaps = 1'b0; stall_pct = 50; end
			endcase
			phase_start = random_sent;
			while (random_sent - phase_start < PHASE_ITEMS) begin
				send_list();
				// now and then the sender waits for the output to drain
				if ($urandom_range(19) == 0)
					wait_idle();
			end
			phase++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Receiver: random stalls, or a long hold-off when a test asks for one
	// ---------------------------------------------------------------------
	initial begin : receiver
		int len;
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
				out_stall <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				len = pick_gap();
				out_stall <= 1'b1;
				repeat (len) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result check: every accepted result against the oldest prediction
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		dlff_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (list_output_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d byte %02h count %0d",
					kind, out_byte, name_count));
			end else begin
				want = list_output_q.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						out_byte, want.data));
				if (name_count !== want.count)
					report_mismatch($sformatf("name_count %0d, expected %0d",
						name_count, want.count));
				if (is_last !== want.last)
					report_mismatch($sformatf("is_last %0b, expected %0b",
						is_last, want.last));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("delimited_file_list_filter_core: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_registers();
		test_small_capacity();
		test_capacity_limit();
		sender_gaps = 1'b1;
		stall_pct   = 20;
		test_backpressure();
		test_random_lists();
		wait_idle();
		if (mismatch_count == 0)
			$display("delimited_file_list_filter_core: match");
		else
			$display("delimited_file_list_filter_core: mismatch");
		$finish;
	end

endmodule
